[rtl/core/dhop_pkg.sv]
`timescale 1ns / 1ps

package dhop_pkg;

    // Longest string whose offsets are tracked; the byte position saturates here.
    localparam int MAX_LENGTH = 4096;
    localparam int POS_W      = $clog2(MAX_LENGTH + 1);
    localparam int VAL_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_SUFFIX = 3'd4,
        PH_IGNORE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_TEN     = 2'd0,
        RADIX_EIGHT   = 2'd1,
        RADIX_SIXTEEN = 2'd2
    } t_radix;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_MAC,
        VAL_SHIFT,
        VAL_ACC
    } t_valsel;

    typedef enum logic [1:0] {
        OFF_Q,
        OFF_Q_NEXT,
        OFF_Q_PREV
    } t_offsel;

    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_MAC,
        ACC_SHIFT
    } t_accop;

    // One classified character, as it travels from front to back.
    typedef struct packed {
        logic             blank;
        logic             nul;
        logic             zero_ch;
        logic             x_ch;
        logic             plus_ch;
        logic             minus_ch;
        logic             hex_ok;
        logic [3:0]       hex_val;
        logic [2:0]       suf_pow;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pos_next;
    } t_char_info;

    // Decoded action of the back end for one character.
    typedef struct packed {
        logic    fire;
        t_status status;
        t_valsel valsel;
        t_offsel offsel;
        t_phase  go_phase;
        t_accop  acc_op;
        logic    radix_wr;
        t_radix  radix_val;
        logic    neg_wr;
    } t_step;

endpackage

[rtl/core/dhop_front.sv]
`timescale 1ns / 1ps

module dhop_front
    import dhop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_push,
    output t_char_info        o_info
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  pos_sat;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] hex_wide;

    assign c       = i_character;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign pos_sat = (r_pos < POS_W'(MAX_LENGTH)) ? r_pos + POS_W'(1) : POS_W'(MAX_LENGTH);

    always_comb begin
        hex_wide = '0;
        o_info.hex_ok = 1'b1;
        if (c >= "0" && c <= "9") begin
            hex_wide = c - CHAR_W'("0");
        end else if (c >= "a" && c <= "f") begin
            hex_wide = c - CHAR_W'("a") + CHAR_W'(10);
        end else if (c >= "A" && c <= "F") begin
            hex_wide = c - CHAR_W'("A") + CHAR_W'(10);
        end else begin
            o_info.hex_ok = 1'b0;
        end
        o_info.hex_val = hex_wide[3:0];

        unique case (c)
            "k", "K": o_info.suf_pow = 3'd1;
            "m", "M": o_info.suf_pow = 3'd2;
            "g", "G": o_info.suf_pow = 3'd3;
            "t", "T": o_info.suf_pow = 3'd4;
            default:  o_info.suf_pow = 3'd0;
        endcase

        o_info.blank    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        o_info.nul      = (c == 8'h00);
        o_info.zero_ch  = (c == "0");
        o_info.x_ch     = (c == "x") || (c == "X");
        o_info.plus_ch  = (c == "+");
        o_info.minus_ch = (c == "-");
        o_info.last     = i_last;
        o_info.pos      = r_pos;
        o_info.pos_next = pos_sat;
    end

    // Byte index within the current string; every flagged-last byte ends a string.
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            n_pos = i_last ? '0 : pos_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[rtl/core/dhop_queue.sv]
`timescale 1ns / 1ps

module dhop_queue
    import dhop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_char_info i_wdata,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_pop,
    output t_char_info o_rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_char_info       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[rtl/core/dhop_back.sv]
`timescale 1ns / 1ps

module dhop_back
    import dhop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_info_valid,
    input  t_char_info        i_info,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VAL_W-1:0]  o_value,
    output logic [1:0]        o_status,
    output logic [POS_W-1:0]  o_offset
);

    t_phase           r_phase;
    t_phase           n_phase;
    t_radix           r_radix;
    t_radix           n_radix;
    logic             r_neg;
    logic             n_neg;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] n_acc;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_mag;
    logic             r_out_neg;
    t_status          r_out_status;
    logic [POS_W-1:0] r_out_offset;

    t_char_info       ci;
    t_step            s;
    t_radix           eff_radix;
    logic             digit_ok;
    logic             sod;
    logic             td;
    logic             go;
    logic [VAL_W-1:0] mac;
    logic [VAL_W-1:0] shifted;
    logic [VAL_W-1:0] res_mag;
    logic             res_neg;
    logic [POS_W-1:0] res_off;

    assign ci    = i_info;
    assign go    = i_info_valid && (!r_out_valid || i_ready);
    assign o_pop = go;

    // A digit right after a leading zero is octal.
    assign eff_radix = (r_phase == PH_ZERO) ? RADIX_EIGHT : r_radix;

    always_comb begin
        unique case (eff_radix)
            RADIX_EIGHT: begin
                digit_ok = (ci.hex_val < 4'd8);
                mac      = {r_acc[VAL_W-4:0], 3'b000} + {{(VAL_W-4){1'b0}}, ci.hex_val};
            end
            RADIX_SIXTEEN: begin
                digit_ok = 1'b1;
                mac      = {r_acc[VAL_W-5:0], ci.hex_val};
            end
            default: begin
                digit_ok = (ci.hex_val < 4'd10);
                mac      = {r_acc[VAL_W-4:0], 3'b000} + {r_acc[VAL_W-2:0], 1'b0}
                         + {{(VAL_W-4){1'b0}}, ci.hex_val};
            end
        endcase
    end

    always_comb begin
        unique case (ci.suf_pow)
            3'd1:    shifted = r_acc << 10;
            3'd2:    shifted = r_acc << 20;
            3'd3:    shifted = r_acc << 30;
            3'd4:    shifted = r_acc << 40;
            default: shifted = r_acc;
        endcase
    end

    // Decode: what this character does, given the phase.
    always_comb begin
        s.fire      = 1'b0;
        s.status    = ST_OK;
        s.valsel    = VAL_ZERO;
        s.offsel    = OFF_Q;
        s.go_phase  = r_phase;
        s.acc_op    = ACC_KEEP;
        s.radix_wr  = 1'b0;
        s.radix_val = RADIX_TEN;
        s.neg_wr    = 1'b0;
        sod         = 1'b0;
        td          = 1'b0;

        unique case (r_phase)
            PH_SKIP: begin
                if (ci.blank) begin
                    if (ci.last) begin
                        s.fire   = 1'b1;
                        s.status = ST_EMPTY;
                        s.offsel = OFF_Q_NEXT;
                    end
                end else if (ci.nul) begin
                    s.fire   = 1'b1;
                    s.status = ST_EMPTY;
                end else if (ci.zero_ch && !ci.last) begin
                    s.go_phase = PH_ZERO;
                end else begin
                    sod = 1'b1;
                end
            end
            PH_ZERO: begin
                if (ci.blank) begin
                    s.fire = 1'b1;
                end else if (ci.x_ch) begin
                    s.radix_wr  = 1'b1;
                    s.radix_val = RADIX_SIXTEEN;
                    if (ci.last) begin
                        s.fire   = 1'b1;
                        s.offsel = OFF_Q_NEXT;
                    end else begin
                        s.go_phase = PH_SIGN;
                    end
                end else begin
                    s.radix_wr  = 1'b1;
                    s.radix_val = RADIX_EIGHT;
                    sod         = 1'b1;
                end
            end
            PH_SIGN: begin
                sod = 1'b1;
            end
            PH_DIGITS: begin
                td = 1'b1;
            end
            PH_SUFFIX: begin
                s.fire = 1'b1;
                if (ci.nul || ci.blank) begin
                    s.valsel = VAL_ACC;
                    s.offsel = OFF_Q_PREV;
                end else begin
                    s.status = ST_INVALID;
                end
            end
            default: begin
                // ignore rest of string
            end
        endcase

        if (sod) begin
            if (!ci.last && (ci.plus_ch || ci.minus_ch)) begin
                s.neg_wr   = 1'b1;
                s.go_phase = PH_DIGITS;
            end else begin
                td = 1'b1;
            end
        end

        if (td) begin
            if (ci.hex_ok) begin
                if (!digit_ok) begin
                    s.fire   = 1'b1;
                    s.status = ST_INVALID;
                end else begin
                    s.acc_op   = ACC_MAC;
                    s.go_phase = PH_DIGITS;
                    if (ci.last) begin
                        s.fire   = 1'b1;
                        s.valsel = VAL_MAC;
                        s.offsel = OFF_Q_NEXT;
                    end
                end
            end else if (ci.suf_pow != 3'd0) begin
                s.acc_op = ACC_SHIFT;
                if (ci.last) begin
                    s.fire   = 1'b1;
                    s.valsel = VAL_SHIFT;
                end else begin
                    s.go_phase = PH_SUFFIX;
                end
            end else if (ci.nul || ci.blank) begin
                s.fire   = 1'b1;
                s.valsel = VAL_ACC;
            end else begin
                s.fire   = 1'b1;
                s.status = ST_INVALID;
            end
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (go) begin
            if (ci.last) begin
                n_phase = PH_SKIP;
                n_radix = RADIX_TEN;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                n_phase = s.fire ? PH_IGNORE : s.go_phase;
                if (s.radix_wr) begin
                    n_radix = s.radix_val;
                end
                if (s.neg_wr) begin
                    n_neg = ci.minus_ch;
                end
                unique case (s.acc_op)
                    ACC_MAC:   n_acc = mac;
                    ACC_SHIFT: n_acc = shifted;
                    default:   n_acc = r_acc;
                endcase
            end
        end
    end

    // Result fields
    always_comb begin
        unique case (s.valsel)
            VAL_MAC:   res_mag = mac;
            VAL_SHIFT: res_mag = shifted;
            VAL_ACC:   res_mag = r_acc;
            default:   res_mag = '0;
        endcase
        res_neg = (s.valsel != VAL_ZERO) && r_neg;
        unique case (s.offsel)
            OFF_Q_NEXT: res_off = ci.pos_next;
            OFF_Q_PREV: res_off = (ci.pos != '0) ? ci.pos - POS_W'(1) : '0;
            default:    res_off = ci.pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_radix     <= RADIX_TEN;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            if (go && s.fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && s.fire) begin
            r_out_mag    <= res_mag;
            r_out_neg    <= res_neg;
            r_out_status <= s.status;
            r_out_offset <= res_off;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_neg ? (VAL_W'(0) - r_out_mag) : r_out_mag;
    assign o_status = r_out_status;
    assign o_offset = r_out_offset;

endmodule

[rtl/core/decimal_hex_octal_number_parser_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------
// input    | in        | i_valid / o_ready  | i_character[7:0], i_last
// result   | out       | o_valid / i_ready  | o_value[63:0] (signed), o_status[1:0],
//          |           |                    | o_offset[12:0]
//
// One character per clock sustained while the queue has room. A character that
// ends a number passes the queue stage, then the output register, before its
// result can transfer.
// The 64-bit multiply-add of the digit step in the back end sets the clock.
// Reset (synchronous, active low) empties the queue and the output register and
// returns the parser to the blank-skipping phase with a zeroed accumulator.
// A stalled result only holds the back end; the two-entry queue keeps the input
// side taking characters until it fills.

module decimal_hex_octal_number_parser_unit
    import dhop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VAL_W-1:0]  o_value,
    output logic [1:0]        o_status,
    output logic [POS_W-1:0]  o_offset
);

    // Front: classify each byte and tag it with its index in the string.
    logic       front_push;
    t_char_info front_info;
    logic       q_full;

    // Queue to back end.
    logic       q_valid;
    t_char_info q_info;
    logic       back_pop;

    dhop_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_last      (i_last),
        .i_full      (q_full),
        .o_push      (front_push),
        .o_info      (front_info)
    );

    dhop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_info),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (back_pop),
        .o_rdata (q_info)
    );

    // Back: phase machine, accumulator and result register.
    dhop_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_info_valid (q_valid),
        .i_info       (q_info),
        .o_pop        (back_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_offset     (o_offset)
    );

endmodule

[tb/dhop_parse_check.sv]
`timescale 1ns / 1ps

module dhop_parse_check
    import dhop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_char_valid,
    input  logic              i_char_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_last,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [1:0]        i_status,
    input  logic [POS_W-1:0]  i_offset,
    output int                o_errors,
    output int                o_pending,
    output int                o_chars,
    output int                o_numbers,
    output int                o_empties,
    output int                o_rejects
);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_G_UP  = 8'h47;
    localparam logic [CHAR_W-1:0] CH_K_UP  = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_M_UP  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_T_UP  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G_LO  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_K_LO  = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_M_LO  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_T_LO  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [4:0]        DIGIT_NONE = 5'd16;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
        logic [POS_W-1:0] offset;
    } t_parse_result;

    t_parse_result parses_due[$];

    // predicted parser state
    t_phase           parse_phase;
    t_radix           radix;
    logic             negate;
    logic [VAL_W-1:0] acc;
    logic [POS_W-1:0] pos;

    int errors;
    int chars;
    int numbers;
    int empties;
    int rejects;

    initial begin
        errors  = 0;
        chars   = 0;
        numbers = 0;
        empties = 0;
        rejects = 0;
    end

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [POS_W-1:0] pos_after(input logic [POS_W-1:0] q);
        return (q < POS_W'(MAX_LENGTH)) ? q + POS_W'(1) : POS_W'(MAX_LENGTH);
    endfunction

    function automatic logic [VAL_W-1:0] signed_acc();
        return negate ? -acc : acc;
    endfunction

    task automatic clear_parser();
        parse_phase = PH_SKIP;
        radix       = RADIX_TEN;
        negate      = 1'b0;
        acc         = '0;
        pos         = '0;
    endtask

    task automatic emit_parse(input logic [VAL_W-1:0] v, input t_status st,
                              input logic [POS_W-1:0] off, input logic lst);
        parses_due.push_back('{value: v, status: st, offset: off});
        if (lst) begin
            clear_parser();
        end else begin
            parse_phase = PH_IGNORE;
        end
    endtask

    task automatic take_digit(input logic [CHAR_W-1:0] c, input logic lst,
                              input logic [POS_W-1:0] q);
        logic [4:0]       dv;
        logic [VAL_W-1:0] base;
        int               pw;
        case (radix)
            RADIX_SIXTEEN: base = 64'd16;
            RADIX_EIGHT:   base = 64'd8;
            default:       base = 64'd10;
        endcase
        dv = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            dv = 5'(c - CH_0);
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            dv = 5'(c - CH_A_LO + 8'd10);
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            dv = 5'(c - CH_A_UP + 8'd10);
        end
        case (c)
            CH_K_LO, CH_K_UP: pw = 1;
            CH_M_LO, CH_M_UP: pw = 2;
            CH_G_LO, CH_G_UP: pw = 3;
            CH_T_LO, CH_T_UP: pw = 4;
            default:          pw = 0;
        endcase
        if (dv != DIGIT_NONE) begin
            if (VAL_W'(dv) >= base) begin
                emit_parse('0, ST_INVALID, q, lst);
            end else begin
                acc         = acc * base + VAL_W'(dv);
                parse_phase = PH_DIGITS;
                if (lst) emit_parse(signed_acc(), ST_OK, pos_after(q), lst);
            end
        end else if (pw != 0) begin
            // binary multiplier: 1024 per step
            acc = acc << (10 * pw);
            if (lst) begin
                emit_parse(signed_acc(), ST_OK, q, lst);
            end else begin
                parse_phase = PH_SUFFIX;
            end
        end else if (c == CH_NUL || is_blank(c)) begin
            emit_parse(signed_acc(), ST_OK, q, lst);
        end else begin
            emit_parse('0, ST_INVALID, q, lst);
        end
    endtask

    // a sign only counts when more characters follow it
    task automatic sign_or_digit(input logic [CHAR_W-1:0] c, input logic lst,
                                 input logic [POS_W-1:0] q);
        if (!lst && (c == CH_MINUS || c == CH_PLUS)) begin
            negate      = (c == CH_MINUS);
            parse_phase = PH_DIGITS;
        end else begin
            take_digit(c, lst, q);
        end
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic lst);
        logic [POS_W-1:0] q;
        q   = pos;
        pos = pos_after(q);
        case (parse_phase)
            PH_SKIP: begin
                if (is_blank(c)) begin
                    if (lst) emit_parse('0, ST_EMPTY, pos_after(q), lst);
                end else if (c == CH_NUL) begin
                    emit_parse('0, ST_EMPTY, q, lst);
                end else if (c == CH_0 && !lst) begin
                    parse_phase = PH_ZERO;
                end else begin
                    sign_or_digit(c, lst, q);
                end
            end
            PH_ZERO: begin
                if (is_blank(c)) begin
                    emit_parse('0, ST_OK, q, lst);
                end else if (c == CH_X_LO || c == CH_X_UP) begin
                    radix = RADIX_SIXTEEN;
                    if (lst) begin
                        emit_parse('0, ST_OK, pos_after(q), lst);
                    end else begin
                        parse_phase = PH_SIGN;
                    end
                end else begin
                    radix = RADIX_EIGHT;
                    sign_or_digit(c, lst, q);
                end
            end
            PH_SIGN:   sign_or_digit(c, lst, q);
            PH_DIGITS: take_digit(c, lst, q);
            PH_SUFFIX: begin
                // offset points back at the suffix letter
                if (c == CH_NUL || is_blank(c)) begin
                    emit_parse(signed_acc(), ST_OK, (q != '0) ? q - POS_W'(1) : '0, lst);
                end else begin
                    emit_parse('0, ST_INVALID, q, lst);
                end
            end
            default: begin
                if (lst) clear_parser();
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_parse_result due;
        if (!i_rst_n) begin
            clear_parser();
            parses_due.delete();
        end else begin
            // results first: a result can never belong to a character taken at this edge
            if (i_res_valid && i_res_ready) begin
                if (parses_due.size() == 0) begin
                    $display("%0t: unexpected result value %h status %0d offset %0d",
                             $time, i_value, i_status, i_offset);
                    errors++;
                end else begin
                    due = parses_due.pop_front();
                    if (i_value !== due.value) begin
                        $display("%0t: value expected %h (%0d) got %h (%0d)", $time,
                                 due.value, $signed(due.value), i_value, $signed(i_value));
                        errors++;
                    end
                    if (i_status !== due.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, due.status, i_status);
                        errors++;
                    end
                    if (i_offset !== due.offset) begin
                        $display("%0t: offset expected %0d got %0d",
                                 $time, due.offset, i_offset);
                        errors++;
                    end
                    case (due.status)
                        ST_OK:    numbers++;
                        ST_EMPTY: empties++;
                        default:  rejects++;
                    endcase
                end
            end
            if (i_char_valid && i_char_ready) begin
                parse_char(i_character, i_last);
                chars++;
            end
        end
        o_errors  <= errors;
        o_pending <= parses_due.size();
        o_chars   <= chars;
        o_numbers <= numbers;
        o_empties <= empties;
        o_rejects <= rejects;
    end

endmodule

[tb/decimal_hex_octal_number_parser_unit_tb.sv]
`timescale 1ns / 1ps

module decimal_hex_octal_number_parser_unit_tb
    import dhop_pkg::*;
;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_CHARS = 1300;
    // no transfer on either side for this long means the block is hung
    localparam int STALL_LIMIT  = 1000;
    // margin left for results after the closing character
    localparam int DRAIN_CYCLES = 8;

    localparam string BLANKS   = " \t\r\n";
    localparam string DEC      = "0123456789";
    localparam string OCT      = "01234567";
    localparam string HEX      = "0123456789abcdefABCDEF";
    localparam string SUFFIXES = "kKmMgGtT";
    // characters the parser reacts to; noise leans on these
    localparam string SPICY    = "0xX+-kKmMgGtT \t9fF8";

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_character = '0;
    logic              i_last      = 1'b0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [VAL_W-1:0]  o_value;
    logic [1:0]        o_status;
    logic [POS_W-1:0]  o_offset;

    int errors;
    int pending;
    int chars;
    int numbers;
    int empties;
    int rejects;

    // characters of the string being built, sent with last on the final one
    logic [CHAR_W-1:0] text[$];
    int                sent = 0;
    // when set the current string goes out back to back, no gaps
    bit                steady = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimal_hex_octal_number_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_offset    (o_offset)
    );

    dhop_parse_check u_parse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_valid),
        .i_char_ready (o_ready),
        .i_character  (i_character),
        .i_last       (i_last),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_value      (o_value),
        .i_status     (o_status),
        .i_offset     (o_offset),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_chars      (chars),
        .o_numbers    (numbers),
        .o_empties    (empties),
        .o_rejects    (rejects)
    );

    // Gap length: mostly none, often short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
    endtask

    // Push the built string through the input channel, one transfer per
    // character. Valid only drops when a gap is inserted, so back-to-back
    // characters never see valid lowered and raised in the same step.
    task automatic send_text();
        int gap;
        for (int k = 0; k < text.size(); k++) begin
            gap = steady ? 0 : idle_len();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_character <= text[k];
            i_last      <= (k == text.size() - 1);
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            sent++;
        end
        text.delete();
    endtask

    // Well-formed number: blanks, base prefix, sign, digits of that base,
    // optional multiplier, then maybe a blank, NUL or random byte and trailing
    // junk that the parser has to skip until the end of the string.
    task automatic put_number();
        string digits;
        int    n;
        int    r;
        repeat ($urandom_range(0, 3)) text.push_back(pick(BLANKS));
        r = $urandom_range(0, 3);
        if (r == 0) begin
            digits = DEC;
        end else if (r == 1) begin
            put_str("0");
            digits = OCT;
        end else begin
            put_str((r == 2) ? "0x" : "0X");
            digits = HEX;
        end
        r = $urandom_range(0, 2);
        if (r == 1) put_str("-");
        if (r == 2) put_str("+");
        // mostly short; sometimes long enough to wrap the 64-bit value
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) begin
            repeat (n) text.push_back(digits[digits.len() - 1]);
        end else begin
            repeat (n) text.push_back(pick(digits));
        end
        if ($urandom_range(0, 3) == 0) text.push_back(pick(SUFFIXES));
        r = $urandom_range(0, 3);
        if (r == 1) text.push_back(pick(BLANKS));
        if (r == 2) text.push_back('0);
        if (r == 3) text.push_back(CHAR_W'($urandom_range(0, 255)));
        if (r != 0) begin
            repeat ($urandom_range(0, 3)) text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    // Result side: ready runs of random length broken by random stalls.
    initial begin
        int stall;
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12))
                @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending);
                $display("decimal_hex_octal_number_parser_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int goal;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed strings ----
        // single digit ending the string
        put_str("7");
        send_text();
        // blanks only
        put_str(" \t\r\n");
        send_text();
        // NUL while still skipping blanks, rest of string ignored
        text.push_back('0);
        put_str("9");
        send_text();
        // hex prefix with nothing after it
        put_str("0x");
        send_text();
        // sign as the final character is rejected
        put_str("-");
        send_text();
        // multiplier on the final character
        put_str("0Xfk");
        send_text();
        // multiplier followed by something other than NUL or blank
        put_str("3g!");
        send_text();
        // lone zero ended by a blank
        put_str("0 ");
        send_text();
        // digit outside octal range
        put_str("08");
        send_text();
        // top code point
        text.push_back('1);
        send_text();
        // sign, multiplier, then NUL terminator
        put_str("+1t");
        text.push_back('0);
        send_text();

        // ---- random strings ----
        // mostly well-formed numbers, some with one character corrupted,
        // the rest plain noise
        goal = sent + RANDOM_CHARS;
        while (sent < goal) begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 19);
            if (r < 14) begin
                put_number();
            end else if (r < 17) begin
                put_number();
                text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 3);
                    if (r == 0) begin
                        text.push_back('0);
                    end else if (r == 1) begin
                        text.push_back(pick(SPICY));
                    end else begin
                        text.push_back(CHAR_W'($urandom_range(0, 255)));
                    end
                end
            end
            send_text();
        end
        i_valid <= 1'b0;

        // let the checker register the final character, then drain results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters; results: %0d numbers, %0d empty, %0d rejected.",
                 chars, numbers, empties, rejects);
        $display("Mismatches: %0d, results still outstanding: %0d.", errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("decimal_hex_octal_number_parser_unit_tb: PASS");
        end else begin
            $display("decimal_hex_octal_number_parser_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
